// ===== sv/mieu_pkg.sv =====
// ----------------------------------------------------------------------------
// mieu_pkg
// Shared types and constants for the MIPS integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

  localparam int DMEM_WORDS = 1024;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  localparam logic [31:0] SYS_EXIT   = 32'd10;
  localparam logic [31:0] SYS_EXIT2  = 32'd17;
  localparam logic [4:0]  REG_V0     = 5'd2;
  localparam logic [4:0]  REG_A0     = 5'd4;
  localparam logic [4:0]  REG_RA     = 5'd31;

  localparam int OUT_W = 240;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clear;      // clearing pass writes zero at clr_cnt
    logic load;       // capture instruction and read operands
    logic exec;       // execute decoded instruction
    logic mul_step;   // copy the registered product into hi/lo
    logic div_start;
    logic div_step;
    logic finish;     // commit results and load output register
  } mieu_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic halted;
    logic is_mul;
    logic is_div;
    logic div_done;
    logic clr_last;
  } mieu_stat_t;

endpackage

// ===== sv/mieu_ram.sv =====
// ----------------------------------------------------------------------------
// mieu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mieu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/mieu_datapath.sv =====
// ----------------------------------------------------------------------------
// mieu_datapath
// Register file, hi/lo, pc, multiply, iterative divide and data memory.
// ----------------------------------------------------------------------------
module mieu_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  mieu_pkg::mieu_cmd_t       cmd,
  output mieu_pkg::mieu_stat_t      stat,
  input  logic [31:0]               instr_in,
  input  logic                      cfg_we,
  input  logic [31:0]               cfg_data,
  output logic [31:0]               start_pc,
  output logic [mieu_pkg::OUT_W-1:0] result
);
  import mieu_pkg::*;

  logic [31:0] regs [32];
  logic [31:0] hi, lo, pc, exit_latch;
  logic        halted;
  logic [31:0] ir, a, b, v0, a0;
  logic [DMEM_AW:0] clr_cnt;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, pc4;

  assign op   = ir[31:26];
  assign rs   = ir[25:21];
  assign rt   = ir[20:16];
  assign rd   = ir[15:11];
  assign sh   = ir[10:6];
  assign fn   = ir[5:0];
  assign imm  = {16'd0, ir[15:0]};
  assign simm = {{16{ir[15]}}, ir[15:0]};
  assign pc4  = pc + 32'd4;

  // Multiply: 33x33 signed product registered, then split.
  logic signed [32:0] ma, mb;
  logic [63:0]        prod;
  assign ma = {(fn == FN_MULT) & a[31], a};
  assign mb = {(fn == FN_MULT) & b[31], b};

  // Restoring divider, one quotient bit per cycle.
  logic [31:0] dq, dr, dd, dv;
  logic [5:0]  dcnt;
  logic        dna, dnb;
  logic [33:0] dtrial;
  assign dtrial = {1'b0, dr, dq[31]} - {2'b00, dd};

  // Data memory.
  logic             ram_we;
  logic [DMEM_AW-1:0] ram_addr, ea_idx;
  logic [31:0]      ram_wdata, ram_rdata, ea;
  assign ea     = a + simm;
  assign ea_idx = ea[DMEM_AW+1:2];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ea_idx;
    ram_wdata = b;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt[DMEM_AW-1:0];
      ram_wdata = 32'd0;
    end else if (cmd.exec && !halted && op == OP_SW) begin
      ram_we = 1'b1;
    end
  end

  mieu_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Decode and execute.
  logic        wv, mv, sv;
  logic [4:0]  wi;
  logic [31:0] wval, npc;
  logic        wv_q, mv_q, sv_q;
  logic [4:0]  wi_q;
  logic [31:0] wval_q, npc_q, maddr_q, mdata_q;

  always_comb begin
    wv = 1'b0; wi = rd; wval = 32'd0; npc = pc4;
    mv = 1'b0; sv = 1'b0;
    if (op == OP_SPECIAL) begin
      case (fn)
        FN_ADD, FN_ADDU: begin wv = 1'b1; wval = a + b; end
        FN_SUB, FN_SUBU: begin wv = 1'b1; wval = a - b; end
        FN_AND:  begin wv = 1'b1; wval = a & b; end
        FN_OR:   begin wv = 1'b1; wval = a | b; end
        FN_XOR:  begin wv = 1'b1; wval = a ^ b; end
        FN_SLT:  begin wv = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
        FN_SLTU: begin wv = 1'b1; wval = {31'd0, a < b}; end
        FN_SLL:  begin wv = 1'b1; wval = b << sh; end
        FN_SRL:  begin wv = 1'b1; wval = b >> sh; end
        FN_SRA:  begin wv = 1'b1; wval = $unsigned($signed(b) >>> sh); end
        FN_MFHI: begin wv = 1'b1; wval = hi; end
        FN_MFLO: begin wv = 1'b1; wval = lo; end
        FN_JALR: begin wv = 1'b1; wval = pc4; npc = a; end
        FN_JR:   npc = a;
        FN_SYSCALL: sv = 1'b1;
        default: ;
      endcase
    end else begin
      wi = rt;
      case (op)
        OP_J:    npc = {pc4[31:28], ir[25:0], 2'b00};
        OP_JAL:  begin
          wv = 1'b1; wi = REG_RA; wval = pc4;
          npc = {pc4[31:28], ir[25:0], 2'b00};
        end
        OP_BEQ:  if (a == b) npc = pc4 + {simm[29:0], 2'b00};
        OP_BNE:  if (a != b) npc = pc4 + {simm[29:0], 2'b00};
        OP_ADDI, OP_ADDIU: begin wv = 1'b1; wval = a + simm; end
        OP_ANDI: begin wv = 1'b1; wval = a & imm; end
        OP_ORI:  begin wv = 1'b1; wval = a | imm; end
        OP_XORI: begin wv = 1'b1; wval = a ^ imm; end
        OP_SLTI: begin wv = 1'b1; wval = {31'd0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin wv = 1'b1; wval = {31'd0, a < simm}; end
        OP_LUI:  begin wv = 1'b1; wval = {ir[15:0], 16'd0}; end
        OP_LW:   wv = 1'b1;
        OP_SW:   mv = 1'b1;
        default: ;
      endcase
    end
    if (wi == 5'd0) begin
      wv = 1'b0;
    end
  end

  assign stat.halted   = halted;
  assign stat.is_mul   = op == OP_SPECIAL && (fn == FN_MULT || fn == FN_MULTU);
  assign stat.is_div   = op == OP_SPECIAL && (fn == FN_DIV || fn == FN_DIVU);
  assign stat.div_done = dcnt == 6'd32;
  assign stat.clr_last = clr_cnt == (DMEM_AW+1)'(DMEM_WORDS - 1);

  logic [31:0] wfinal;
  assign wfinal = (op == OP_LW) ? ram_rdata : wval_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      halted     <= 1'b0;
      exit_latch <= 32'd0;
      hi         <= 32'd0;
      lo         <= 32'd0;
      start_pc   <= 32'd0;
      pc         <= 32'd0;
      result     <= '0;
      for (int i = 0; i < 32; i++) begin
        regs[i] <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        start_pc <= cfg_data;
        pc       <= cfg_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load) begin
        ir <= instr_in;
        a  <= regs[instr_in[25:21]];
        b  <= regs[instr_in[20:16]];
        v0 <= regs[REG_V0];
        a0 <= regs[REG_A0];
      end
      if (cmd.exec) begin
        wv_q <= wv; wi_q <= wi; wval_q <= wval; npc_q <= npc;
        mv_q <= mv; maddr_q <= ea; mdata_q <= b; sv_q <= sv;
        if (!halted && op == OP_SPECIAL && fn == FN_MTHI) hi <= a;
        if (!halted && op == OP_SPECIAL && fn == FN_MTLO) lo <= a;
        prod <= 64'($signed(ma) * $signed(mb));
      end
      if (cmd.mul_step) begin
        hi <= prod[63:32];
        lo <= prod[31:0];
      end
      if (cmd.div_start) begin
        dna  <= (fn == FN_DIV) & a[31];
        dnb  <= (fn == FN_DIV) & b[31];
        dq   <= ((fn == FN_DIV) & a[31]) ? -a : a;
        dd   <= ((fn == FN_DIV) & b[31]) ? -b : b;
        dv   <= a;
        dr   <= 32'd0;
        dcnt <= 6'd0;
      end
      if (cmd.div_step) begin
        if (!stat.div_done) begin
          dcnt <= dcnt + 6'd1;
          if (!dtrial[33]) begin
            dr <= dtrial[31:0];
            dq <= {dq[30:0], 1'b1};
          end else begin
            dr <= {dr[30:0], dq[31]};
            dq <= {dq[30:0], 1'b0};
          end
        end else if (dd == 32'd0) begin
          lo <= 32'hFFFF_FFFF;
          hi <= dv;
        end else begin
          lo <= (dna != dnb) ? -dq : dq;
          hi <= dna ? -dr : dr;
        end
      end
      if (cmd.finish) begin
        if (halted) begin
          result <= {7'd0, exit_latch, 1'b1, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0,
                     32'd0, 5'd0, 1'b0, pc};
        end else begin
          logic       hnow;
          logic [31:0] ex;
          hnow = sv_q && (v0 == SYS_EXIT || v0 == SYS_EXIT2);
          ex   = (v0 == SYS_EXIT2) ? a0 : 32'd0;
          if (hnow) begin
            halted     <= 1'b1;
            exit_latch <= ex;
          end
          if (wv_q) regs[wi_q] <= wfinal;
          pc <= npc_q;
          result <= {7'd0, hnow ? ex : 32'd0, hnow,
                     sv_q ? a0 : 32'd0, sv_q ? v0 : 32'd0, sv_q,
                     mv_q ? mdata_q : 32'd0, mv_q ? maddr_q : 32'd0, mv_q,
                     wv_q ? wfinal : 32'd0, wv_q ? wi_q : 5'd0, wv_q, npc_q};
        end
      end
    end
  end

endmodule

// ===== sv/mieu_control.sv =====
// ----------------------------------------------------------------------------
// mieu_control
// Sequencer: clearing pass, then load, execute, optional multi-cycle work,
// commit, and the output handshake.
// ----------------------------------------------------------------------------
module mieu_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output mieu_pkg::mieu_cmd_t  cmd,
  input  mieu_pkg::mieu_stat_t stat
);
  import mieu_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_full, out_full_next;

  assign s_tready = state == ST_IDLE && !out_full;
  assign m_tvalid = out_full;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    out_full_next = out_full && !m_tready;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.halted) state_next = ST_FIN;
        else if (stat.is_mul) state_next = ST_MUL;
        else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else state_next = ST_FIN;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish    = 1'b1;
        out_full_next = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

// ===== sv/mips_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// Executes one MIPS I instruction word per transaction and reports its effects.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-word data memory, one word per cycle,
// and accepts no instruction until that clearing pass is done. Each instruction
// then passes through load, execute, commit and output; a multiply adds a step
// that moves the product into hi/lo, and a divide runs a one-bit-per-cycle divider.
module mips_integer_execute_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // instruction_word
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc, reg_write_valid, reg_write_index, reg_write_value, mem_write_valid,
  // mem_write_addr, mem_write_data, syscall_valid, syscall_code, syscall_arg,
  // halted_now, exit_status
  output logic [239:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mieu_pkg::*;

  mieu_cmd_t   cmd;
  mieu_stat_t  stat;
  logic        cfg_we;
  logic [31:0] start_pc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr == 2'd0;
  assign prdata = (paddr == 2'd0) ? start_pc : 32'd0;

  mieu_control u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .stat(stat)
  );

  mieu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .instr_in(s_tdata),
    .cfg_we(cfg_we), .cfg_data(pwdata), .start_pc(start_pc), .result(m_tdata)
  );

endmodule
